// ===== hdl/link_pair_list_parser_core_assert.svh =====
// Assertion macros for the link pair list parser.
// Used by the core top level; needs a clock named clk and reset named rst.
`ifndef LINK_PAIR_LIST_PARSER_CORE_ASSERT_SVH
`define LINK_PAIR_LIST_PARSER_CORE_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define LPP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Implication checked at every clock edge outside reset.
`define LPP_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lpp_pkg.sv =====
// Shared types and constants for the link pair list parser.
// No dependencies; used by lpp_parser and link_pair_list_parser_core.
package lpp_pkg;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned WCOUNT_W = 10;
  localparam int unsigned ID_W     = 10;
  localparam int unsigned ACC_W    = 16;
  localparam int unsigned STORED_W = 11;
  localparam int unsigned TALLY_W  = 12;

  localparam logic [CHAR_W-1:0] CH_NUL  = 8'd0;
  localparam logic [CHAR_W-1:0] CH_TAB  = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR   = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SP   = 8'd32;
  localparam logic [CHAR_W-1:0] CH_LPAR = 8'd40;
  localparam logic [CHAR_W-1:0] CH_RPAR = 8'd41;
  localparam logic [CHAR_W-1:0] CH_ZERO = 8'd48;
  localparam logic [CHAR_W-1:0] CH_NINE = 8'd57;
  localparam logic [CHAR_W-1:0] CH_BAR  = 8'd124;

  localparam logic [ACC_W-1:0]    OLD_END_ID   = 16'd3000;
  localparam logic [ID_W-1:0]     NEW_END_ID   = 10'd1000;
  localparam logic [ACC_W-1:0]    ACC_MAX      = 16'hFFFF;
  localparam logic [TALLY_W-1:0]  TALLY_MAX    = 12'hFFF;
  localparam logic [STORED_W-1:0] STORED_MAX   = 11'h7FF;
  localparam logic [STORED_W-1:0] PAIR_LIMIT   = 11'd1024;
  localparam logic [WCOUNT_W-1:0] WCOUNT_RESET = 10'd1000;

  localparam logic KIND_PAIR    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [ID_W-1:0]     target_id;
    logic [ACC_W-1:0]    pair_count;
    logic [STORED_W-1:0] pairs_stored;
    logic [TALLY_W-1:0]  bad_count;
    logic [TALLY_W-1:0]  remap_count;
    logic                last;
  } result_t;

  // Results produced by one character: an optional pair and an optional summary.
  typedef struct packed {
    logic    pair_valid;
    logic    sum_valid;
    result_t pair;
    result_t sum;
  } push_t;

endpackage

// ===== hdl/link_pair_list_parser_core.sv =====
// Top level of the link pair list parser: parse state machine plus result queue.
// Depends on lpp_pkg, lpp_parser and link_pair_list_parser_core_assert.svh.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------
//  in      | in_valid / in_ready  | char_code, last_char
//  out     | out_valid/ out_ready | result_kind, target_id, pair_count,
//          |                      | pairs_stored, bad_count, remap_count, is_last
//  cfg     | cfg_wr_en            | cfg_wr_data (declared word count)
//
// One character is taken per cycle while in_ready is high; its results are
// queued on the next edge. Each gives up to two results, which leave a four-entry
// queue at one per cycle while out_ready is high; in_ready needs two free entries.
// Reset (rst, synchronous) empties the queue, restores the word count to 1000
// and returns the parser to looking for the bar.
// A stalled output only holds off input once the queue cannot take two more items.
`include "link_pair_list_parser_core_assert.svh"

module link_pair_list_parser_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [lpp_pkg::WCOUNT_W-1:0]  cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lpp_pkg::CHAR_W-1:0]    char_code,
  input  logic                          last_char,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          result_kind,
  output logic [lpp_pkg::ID_W-1:0]      target_id,
  output logic [lpp_pkg::ACC_W-1:0]     pair_count,
  output logic [lpp_pkg::STORED_W-1:0]  pairs_stored,
  output logic [lpp_pkg::TALLY_W-1:0]   bad_count,
  output logic [lpp_pkg::TALLY_W-1:0]   remap_count,
  output logic                          is_last
);

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned PTR_W  = $clog2(QDEPTH);

  lpp_pkg::push_t   push;
  lpp_pkg::result_t queue [QDEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count, count_next;
  logic             in_acc, out_acc;
  logic [PTR_W-1:0] sum_addr;
  logic [1:0]       n_push;
  lpp_pkg::result_t head;

  assign in_ready = (count <= (PTR_W+1)'(QDEPTH - 2));
  assign in_acc   = in_valid && in_ready;
  assign out_valid = (count != '0);
  assign out_acc  = out_valid && out_ready;

  lpp_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (in_acc),
    .char_code   (char_code),
    .last_char   (last_char),
    .push        (push)
  );

  assign n_push     = in_acc ? ({1'b0, push.pair_valid} + {1'b0, push.sum_valid}) : 2'd0;
  assign sum_addr   = wr_ptr + {{(PTR_W-1){1'b0}}, push.pair_valid};
  assign count_next = count + {{(PTR_W-1){1'b0}}, n_push}
                      - {{PTR_W{1'b0}}, out_acc};

  always_ff @(posedge clk) begin
    if (in_acc && push.pair_valid) queue[wr_ptr] <= push.pair;
    if (in_acc && push.sum_valid) queue[sum_addr] <= push.sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push[PTR_W-1:0];
      if (out_acc) rd_ptr <= rd_ptr + 1'b1;
      count <= count_next;
    end
  end

  assign head         = queue[rd_ptr];
  assign result_kind  = head.kind;
  assign target_id    = head.target_id;
  assign pair_count   = head.pair_count;
  assign pairs_stored = head.pairs_stored;
  assign bad_count    = head.bad_count;
  assign remap_count  = head.remap_count;
  assign is_last      = head.last;

  `LPP_ASSERT_ALWAYS(a_queue_bound, count <= (PTR_W+1)'(QDEPTH), "result queue overfilled")
  `LPP_ASSERT_IMPLY(a_count_track, !$past(rst) && $past(in_acc) && !$past(out_acc), count == $past(count) + {{(PTR_W-1){1'b0}}, $past(n_push)}, "queue count lost an item")
  `LPP_ASSERT_IMPLY(a_last_is_summary, out_valid && is_last, result_kind == lpp_pkg::KIND_SUMMARY && target_id == '0 && pair_count == '0, "last item is not a clean summary")
  `LPP_ASSERT_IMPLY(a_pair_fields, out_valid && result_kind == lpp_pkg::KIND_PAIR, target_id != '0 && pair_count != '0 && pairs_stored != '0, "pair item carries a rejected pair")

endmodule

// ===== hdl/lpp_parser.sv =====
// Per-character parse state machine with pair checking and tallies.
// Depends on lpp_pkg; results are handed to the output queue in the top level.
module lpp_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [lpp_pkg::WCOUNT_W-1:0]  cfg_wr_data,
  input  logic                          accept,
  input  logic [lpp_pkg::CHAR_W-1:0]    char_code,
  input  logic                          last_char,
  output lpp_pkg::push_t                push
);

  typedef enum logic [2:0] {
    PH_SEEK,
    PH_PRE_ID,
    PH_ID,
    PH_CNT_START,
    PH_CNT,
    PH_STOP
  } phase_t;

  phase_t                         phase, phase_next;
  logic [lpp_pkg::WCOUNT_W-1:0]   word_count;
  logic [lpp_pkg::ACC_W-1:0]      id_acc, id_acc_next;
  logic [lpp_pkg::ACC_W-1:0]      cnt_acc, cnt_acc_next;
  logic [lpp_pkg::STORED_W-1:0]   stored, stored_next;
  logic [lpp_pkg::TALLY_W-1:0]    bad, bad_next;
  logic [lpp_pkg::TALLY_W-1:0]    remap, remap_next;

  logic       is_digit;
  logic       is_space;
  logic [3:0] digit;
  logic       pair_ok;
  logic       pair_done;
  logic [lpp_pkg::ID_W-1:0] pair_id;

  // acc * 10 + d, held at the accumulator maximum
  function automatic logic [lpp_pkg::ACC_W-1:0] acc_digit(
    input logic [lpp_pkg::ACC_W-1:0] acc,
    input logic [3:0]                d
  );
    logic [lpp_pkg::ACC_W+3:0] wide;
    wide = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {{lpp_pkg::ACC_W{1'b0}}, d};
    if (wide > {4'd0, lpp_pkg::ACC_MAX}) begin
      return lpp_pkg::ACC_MAX;
    end
    return wide[lpp_pkg::ACC_W-1:0];
  endfunction

  assign is_digit = (char_code inside {[lpp_pkg::CH_ZERO:lpp_pkg::CH_NINE]});
  assign is_space = (char_code inside {lpp_pkg::CH_SP, lpp_pkg::CH_TAB,
                                       lpp_pkg::CH_CR, lpp_pkg::CH_LF});
  assign digit    = char_code[3:0];

  always_comb begin
    phase_next   = phase;
    id_acc_next  = id_acc;
    cnt_acc_next = cnt_acc;
    stored_next  = stored;
    bad_next     = bad;
    remap_next   = remap;
    pair_ok      = 1'b0;
    pair_done    = 1'b0;
    pair_id      = id_acc[lpp_pkg::ID_W-1:0];

    if (char_code == lpp_pkg::CH_NUL && phase != PH_STOP) begin
      phase_next = PH_STOP;
    end else begin
      case (phase)
        PH_SEEK: begin
          if (char_code == lpp_pkg::CH_BAR) phase_next = PH_PRE_ID;
        end
        PH_PRE_ID: begin
          if (is_digit) begin
            id_acc_next = {{(lpp_pkg::ACC_W-4){1'b0}}, digit};
            phase_next  = PH_ID;
          end else if (!is_space) begin
            phase_next = PH_STOP;
          end
        end
        PH_ID: begin
          if (is_digit) id_acc_next = acc_digit(id_acc, digit);
          else if (char_code == lpp_pkg::CH_LPAR) phase_next = PH_CNT_START;
          else phase_next = PH_STOP;
        end
        PH_CNT_START: begin
          if (is_digit) begin
            cnt_acc_next = {{(lpp_pkg::ACC_W-4){1'b0}}, digit};
            phase_next   = PH_CNT;
          end else begin
            phase_next = PH_STOP;
          end
        end
        PH_CNT: begin
          if (is_digit) begin
            cnt_acc_next = acc_digit(cnt_acc, digit);
          end else if (char_code == lpp_pkg::CH_RPAR) begin
            pair_done  = 1'b1;
            phase_next = PH_PRE_ID;
            pair_ok    = 1'b1;
            if (id_acc == '0) begin
              pair_ok = 1'b0;
            end else if (id_acc == lpp_pkg::OLD_END_ID) begin
              pair_id = lpp_pkg::NEW_END_ID;
              if (remap != lpp_pkg::TALLY_MAX) remap_next = remap + 1'b1;
            end else if (id_acc > {{(lpp_pkg::ACC_W-lpp_pkg::WCOUNT_W){1'b0}},
                                   word_count}) begin
              pair_ok = 1'b0;
            end
            if (cnt_acc == '0) pair_ok = 1'b0;
            if (!pair_ok) begin
              if (bad != lpp_pkg::TALLY_MAX) bad_next = bad + 1'b1;
            end else if (stored != lpp_pkg::STORED_MAX) begin
              stored_next = stored + 1'b1;
            end
            if (stored_next >= lpp_pkg::PAIR_LIMIT) phase_next = PH_STOP;
          end else begin
            phase_next = PH_STOP;
          end
        end
        default: phase_next = PH_STOP;
      endcase
    end

    push.pair_valid        = pair_done && pair_ok;
    push.pair.kind         = lpp_pkg::KIND_PAIR;
    push.pair.target_id    = pair_id;
    push.pair.pair_count   = cnt_acc;
    push.pair.pairs_stored = stored_next;
    push.pair.bad_count    = bad_next;
    push.pair.remap_count  = remap_next;
    push.pair.last         = 1'b0;

    push.sum_valid         = last_char;
    push.sum.kind          = lpp_pkg::KIND_SUMMARY;
    push.sum.target_id     = '0;
    push.sum.pair_count    = '0;
    push.sum.pairs_stored  = stored_next;
    push.sum.bad_count     = bad_next;
    push.sum.remap_count   = remap_next;
    push.sum.last          = 1'b1;

    // end of string: drop any open pair and start afresh
    if (last_char) begin
      phase_next   = PH_SEEK;
      id_acc_next  = '0;
      cnt_acc_next = '0;
      stored_next  = '0;
      bad_next     = '0;
      remap_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SEEK;
      word_count <= lpp_pkg::WCOUNT_RESET;
      id_acc     <= '0;
      cnt_acc    <= '0;
      stored     <= '0;
      bad        <= '0;
      remap      <= '0;
    end else begin
      if (cfg_wr_en) word_count <= cfg_wr_data;
      if (accept) begin
        phase   <= phase_next;
        id_acc  <= id_acc_next;
        cnt_acc <= cnt_acc_next;
        stored  <= stored_next;
        bad     <= bad_next;
        remap   <= remap_next;
      end
    end
  end

endmodule
